@@ src/skt_pkg.sv @@
// skt_pkg: shared types and constants for the SQL keyword tokenizer.
// Holds token kind codes, character codes, the keyword table and result structs.
// No dependencies.
package skt_pkg;

  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned KIND_W   = 5;
  localparam int unsigned PREFIX_W = 56;
  localparam int unsigned PREFIX_BYTES = 7;
  localparam int unsigned NUM_KW   = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW  = 2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT   = 5'd0,
    KIND_NUMBER  = 5'd1,
    KIND_SELECT  = 5'd2,
    KIND_FROM    = 5'd3,
    KIND_WHERE   = 5'd4,
    KIND_JOIN    = 5'd5,
    KIND_ON      = 5'd6,
    KIND_GROUP   = 5'd7,
    KIND_BY      = 5'd8,
    KIND_EXPLAIN = 5'd9,
    KIND_EQ      = 5'd10,
    KIND_SEMI    = 5'd11,
    KIND_LPAREN  = 5'd12,
    KIND_RPAREN  = 5'd13,
    KIND_COMMA   = 5'd14,
    KIND_STAR    = 5'd15,
    KIND_ILLEGAL = 5'd16,
    KIND_EOF     = 5'd17
  } kind_e;

  // character codes
  localparam logic [CHAR_W-1:0] CH_EOS    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;

  // upper-cased keyword text, packed first byte highest, right-justified
  localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KW] = '{
    56'h0053454C454354,   // SELECT
    56'h00000046524F4D,   // FROM
    56'h00005748455245,   // WHERE
    56'h0000004A4F494E,   // JOIN
    56'h00000000004F4E,   // ON
    56'h000047524F5550,   // GROUP
    56'h00000000004259,   // BY
    56'h4558504C41494E    // EXPLAIN
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd4, 4'd5, 4'd4, 4'd2, 4'd5, 4'd2, 4'd7};
  localparam kind_e KW_KIND [NUM_KW] = '{
    KIND_SELECT, KIND_FROM, KIND_WHERE, KIND_JOIN,
    KIND_ON, KIND_GROUP, KIND_BY, KIND_EXPLAIN
  };

  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   start_res;
    logic [LEN_W-1:0]   length;
    logic [CHAR_W-1:0]  char_value;
    logic               last;
  } tok_t;

  // up to two tokens produced by one byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } push_t;

endpackage

@@ src/skt_if.sv @@
// skt_if: valid/ready channel interfaces for source bytes and tokens.
// Depends on skt_pkg for field widths.
interface skt_in_if import skt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface skt_out_if import skt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  start_res;
  logic [LEN_W-1:0]  length;
  logic [CHAR_W-1:0] char_value;
  logic              last;

  modport source (output valid, output kind, output start_res, output length,
                  output char_value, output last, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input char_value, input last, output ready);
endinterface

@@ src/skt_lexer.sv @@
// skt_lexer: lexer state and byte classification; turns one byte into 0..2 tokens.
// Depends on skt_pkg.
module skt_lexer import skt_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [CHAR_W-1:0] ch_i,
  output push_t             push_o
);

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [PREFIX_W-1:0]      prefix_q, prefix_d;
  logic [LEN_W-1:0]         run_q, run_d;

  logic              is_lower, is_word, is_digit;
  logic [CHAR_W-1:0] up_ch;
  logic [LEN_W-1:0]  pos16, start16, run_inc;
  logic [POSITION_BITS-1:0] pos_inc;
  kind_e             kw_kind;

  assign is_lower = (ch_i >= CH_LO_A) && (ch_i <= CH_LO_Z);
  assign is_word  = is_lower || ((ch_i >= CH_UP_A) && (ch_i <= CH_UP_Z)) ||
                    (ch_i == CH_UNDER) || (ch_i == CH_DOT);
  assign is_digit = (ch_i >= CH_0) && (ch_i <= CH_9);
  assign up_ch    = is_lower ? (ch_i & ~CASE_BIT) : ch_i;

  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign run_inc = (run_q == '1) ? run_q : run_q + 1'b1;

  // report positions in a 16-bit field, clamped
  if (POSITION_BITS > LEN_W) begin : g_sat
    assign pos16   = (pos_q[POSITION_BITS-1:LEN_W] != '0) ? '1 : pos_q[LEN_W-1:0];
    assign start16 = (start_q[POSITION_BITS-1:LEN_W] != '0) ? '1 : start_q[LEN_W-1:0];
  end else begin : g_ext
    assign pos16   = LEN_W'(pos_q);
    assign start16 = LEN_W'(start_q);
  end

  always_comb begin
    kw_kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((run_q == LEN_W'(KW_LEN[k])) && (prefix_q == KW_TEXT[k])) begin
        kw_kind = KW_KIND[k];
      end
    end
  end

  always_comb begin
    tok_t pend_tok, ch_tok;
    logic has_pend, has_ch;

    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    prefix_d = prefix_q;
    run_d    = run_q;
    push_o   = '0;
    pend_tok = '0;
    ch_tok   = '0;
    has_pend = 1'b0;
    has_ch   = 1'b0;

    if (fire_i) begin
      if ((mode_q == MODE_WORD) && is_word) begin
        if (run_q < LEN_W'(PREFIX_BYTES)) begin
          prefix_d = {prefix_q[PREFIX_W-CHAR_W-1:0], up_ch};
        end
        run_d = run_inc;
        pos_d = pos_inc;
      end else if ((mode_q == MODE_NUM) && is_digit) begin
        run_d = run_inc;
        pos_d = pos_inc;
      end else begin
        // a run ends here: flush it ahead of whatever this byte gives
        has_pend           = (mode_q != MODE_IDLE);
        pend_tok.kind      = (mode_q == MODE_WORD) ? kw_kind : KIND_NUMBER;
        pend_tok.start_res = start16;
        pend_tok.length    = run_q;
        mode_d             = MODE_IDLE;
        pos_d              = pos_inc;

        ch_tok.start_res  = pos16;
        ch_tok.length     = LEN_W'(1);
        ch_tok.char_value = ch_i;
        has_ch            = 1'b1;
        case (ch_i) inside
          CH_SPACE, CH_TAB, CH_CR, CH_LF: has_ch = 1'b0;
          CH_EOS: begin
            ch_tok.kind       = KIND_EOF;
            ch_tok.length     = '0;
            ch_tok.char_value = '0;
            pos_d    = '0;
            start_d  = '0;
            prefix_d = '0;
            run_d    = '0;
          end
          CH_EQ:     ch_tok.kind = KIND_EQ;
          CH_SEMI:   ch_tok.kind = KIND_SEMI;
          CH_LPAREN: ch_tok.kind = KIND_LPAREN;
          CH_RPAREN: ch_tok.kind = KIND_RPAREN;
          CH_COMMA:  ch_tok.kind = KIND_COMMA;
          CH_STAR:   ch_tok.kind = KIND_STAR;
          default: begin
            if (is_word) begin
              has_ch   = 1'b0;
              mode_d   = MODE_WORD;
              start_d  = pos_q;
              run_d    = LEN_W'(1);
              prefix_d = PREFIX_W'(up_ch);
            end else if (is_digit) begin
              has_ch   = 1'b0;
              mode_d   = MODE_NUM;
              start_d  = pos_q;
              run_d    = LEN_W'(1);
              prefix_d = '0;
            end else begin
              ch_tok.kind = KIND_ILLEGAL;
            end
          end
        endcase

        ch_tok.last = 1'b1;
        if (has_pend) begin
          pend_tok.last = !has_ch;
          push_o.first  = pend_tok;
          push_o.second = ch_tok;
          push_o.cnt    = has_ch ? 2'd2 : 2'd1;
        end else begin
          push_o.first = ch_tok;
          push_o.cnt   = has_ch ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      prefix_q <= '0;
      run_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      prefix_q <= prefix_d;
      run_q    <= run_d;
    end
  end

endmodule

@@ src/skt_res_fifo.sv @@
// skt_res_fifo: small token queue, takes up to two tokens a cycle, gives one.
// Depends on skt_pkg.
module skt_res_fifo import skt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room2_o,
  output logic  valid_o,
  input  logic  ready_i,
  output tok_t  tok_o
);

  tok_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               pop;
  logic [FIFO_AW-1:0] wr_next;

  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign room2_o = (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign wr_next = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FIFO_AW'(push_i.cnt);
      rd_q  <= rd_q + FIFO_AW'(pop);
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i.cnt) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

@@ src/sql_keyword_tokenizer.sv @@
// sql_keyword_tokenizer: streaming SQL lexer, one source byte per request in,
// one token per request out. A byte waits in the input register until the token queue has room for two tokens,
// then is lexed and its tokens are queued. Throughput: 1 byte per cycle while the queue has that room;
// a byte that ends a run and forms its own token gives two, and the one-token-per-cycle output port sets the pace.
// Reset (async, active low) clears position, pending run and the token queue.
// Depends on skt_pkg, skt_if, skt_lexer and skt_res_fifo.
module sql_keyword_tokenizer import skt_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  skt_in_if.sink          in_i,
  skt_out_if.source       out_o
);

  // input register
  logic              vld_q;
  logic [CHAR_W-1:0] ch_q;
  logic              fire;     // byte in the input register is lexed this cycle
  logic              room2;    // queue can take a full pair of tokens
  push_t             push;
  tok_t              head;

  assign fire       = vld_q && room2;
  assign in_i.ready = !vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      vld_q <= 1'b1;
    end else if (fire) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q <= in_i.ch;
    end
  end

  // classify the byte, update run state, emit up to two tokens
  skt_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .ch_i  (ch_q),
    .push_o(push)
  );

  // tokens wait here so the input keeps flowing under output stalls
  skt_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room2_o(room2),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .tok_o  (head)
  );

  assign out_o.kind       = KIND_W'(head.kind);
  assign out_o.start_res  = head.start_res;
  assign out_o.length     = head.length;
  assign out_o.char_value = head.char_value;
  assign out_o.last       = head.last;

endmodule
